/* rtl/stc_pkg.sv */
// package: sizes, codes and shared types of the sector cache tag store
package stc_pkg;

  localparam int ENTRIES  = 8;
  localparam int TAG_BITS = 32;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int STAMP_W  = 16;

  typedef enum logic [1:0] {
    ACT_LOOKUP    = 2'd0,
    ACT_INV_ONE   = 2'd1,
    ACT_INV_RANGE = 2'd2,
    ACT_INV_ALL   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NOSLOT = 2'd2,
    ST_INVAL  = 2'd3
  } status_t;

  // scan word handed from cell to cell
  typedef struct packed {
    logic                vld;
    logic                en;
    action_t             action;
    logic [TAG_BITS-1:0] lo;
    logic [TAG_BITS-1:0] hi;
    logic                found;
    logic [IDX_W-1:0]    hit_idx;
    logic                have;
    logic [STAMP_W:0]    best_age;
    logic [IDX_W-1:0]    pick;
  } probe_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic [STAMP_W-1:0]  use_ctr;
    logic                alloc_we;
    logic [IDX_W-1:0]    alloc_idx;
    logic [TAG_BITS-1:0] alloc_tag;
    logic                clear_all;
  } ctl_t;

endpackage

/* rtl/stc_ifs.sv */
// interfaces: request and result channels of the sector cache tag store
interface stc_in_if
  import stc_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] sector;
  logic [31:0] sector_last;

  modport source (output valid, action, sector, sector_last, input ready);
  modport sink   (input valid, action, sector, sector_last, output ready);
endinterface

interface stc_out_if
  import stc_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic [15:0] hit_total;

  modport source (output valid, status, slot, hit_total, input ready);
  modport sink   (input valid, status, slot, hit_total, output ready);
endinterface

/* rtl/stc_cell.sv */
// cell: one cache entry plus one stage of the scan chain
module stc_cell
  import stc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  ctl_t             ctl,
  input  probe_t           p_in,
  output probe_t           p_out
);

  logic                valid_r, valid_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  probe_t              p_r, p_nxt;
  logic [STAMP_W-1:0]  age;

  assign age   = ctl.use_ctr - stamp_r;
  assign p_out = p_r;

  always_comb begin
    p_nxt     = p_in;
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    stamp_nxt = stamp_r;
    if (p_in.vld && p_in.en) begin
      case (p_in.action)
        ACT_LOOKUP: begin
          if (!p_in.found) begin
            if (!valid_r) begin
              p_nxt.pick     = cell_idx;
              p_nxt.have     = 1'b1;
              p_nxt.best_age = {1'b1, {STAMP_W{1'b0}}};
            end else if (tag_r == p_in.lo) begin
              p_nxt.found   = 1'b1;
              p_nxt.hit_idx = cell_idx;
              stamp_nxt     = ctl.use_ctr;
            end else if ({1'b0, age} > p_in.best_age) begin
              p_nxt.pick     = cell_idx;
              p_nxt.have     = 1'b1;
              p_nxt.best_age = {1'b0, age};
            end
          end
        end
        ACT_INV_ONE: begin
          if (!p_in.found && tag_r == p_in.lo) begin
            p_nxt.found = 1'b1;
            valid_nxt   = 1'b0;
          end
        end
        ACT_INV_RANGE: begin
          if (tag_r >= p_in.lo && tag_r <= p_in.hi) valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (ctl.clear_all) begin
      valid_nxt = 1'b0;
      tag_nxt   = '0;
      stamp_nxt = '0;
    end else if (ctl.alloc_we && ctl.alloc_idx == cell_idx) begin
      valid_nxt = 1'b1;
      tag_nxt   = ctl.alloc_tag;
      stamp_nxt = ctl.use_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tag_r   <= '0;
      stamp_r <= '0;
      p_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      tag_r   <= tag_nxt;
      stamp_r <= stamp_nxt;
      p_r     <= p_nxt;
    end
  end

endmodule

/* rtl/sector_cache_tag_lru.sv */
// top level: sector cache tag store with lru replacement over a chain of entry cells
//
// A request word (action, sector, sector_last) is taken when in_ch.ready is high; the
// block then runs a scan word down a chain of ENTRIES cells, one cell per cycle, each
// cell holding one entry (valid, tag, 16-bit last-use stamp). Hits restamp and
// invalidates clear as the scan passes; an allocation or an invalidate-all is applied
// when the scan leaves the chain and the result word is loaded into the output register.
// One request is worked on at a time: it passes the launch register, the cell chain and the
// tail register, and the next can be accepted once its result word has been loaded into the
// output register. A new request may be accepted while a result word still waits in the
// output register. The cache_enabled register is at apb address 0 (reset 1); write it only
// while the block is idle.
module sector_cache_tag_lru
  import stc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  stc_in_if.sink      in_ch,
  stc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration register
  logic enabled_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'b0, enabled_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == 1'b0) begin
      enabled_r <= cfg_pwdata[0];
    end
  end

  // control state
  logic               busy_r;
  logic [STAMP_W-1:0] use_ctr_r;
  logic [STAMP_W-1:0] hit_ctr_r;
  probe_t             launch_r;
  probe_t             tail_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [2:0]         out_slot_r;
  logic [15:0]        out_hits_r;

  logic                accept;
  logic                release_w;
  logic [TAG_BITS+31:0] lo_ext, hi_ext;
  probe_t              launch_nxt;
  probe_t              chain [ENTRIES+1];
  ctl_t                ctl;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // sector cut or zero-extended to the tag width
  assign lo_ext = {{TAG_BITS{1'b0}}, in_ch.sector};
  assign hi_ext = {{TAG_BITS{1'b0}}, in_ch.sector_last};

  always_comb begin
    launch_nxt          = '0;
    launch_nxt.vld      = accept;
    launch_nxt.en       = enabled_r;
    launch_nxt.action   = action_t'(in_ch.action);
    launch_nxt.lo       = lo_ext[TAG_BITS-1:0];
    launch_nxt.hi       = hi_ext[TAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= '0;
    end else begin
      launch_r <= launch_nxt;
    end
  end

  // scan chain of entry cells
  assign chain[0] = launch_r;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      stc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(g)),
        .ctl      (ctl),
        .p_in     (chain[g]),
        .p_out    (chain[g+1])
      );
    end
  endgenerate

  // decode of the finished scan word
  logic                is_hit, is_alloc, is_clear;
  status_t             res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [IDX_W+2:0]    res_idx_ext;
  logic [STAMP_W-1:0]  hit_nxt;

  assign release_w = tail_r.vld && (!out_valid_r || out_ch.ready);

  always_comb begin
    is_hit     = 1'b0;
    is_alloc   = 1'b0;
    is_clear   = 1'b0;
    res_idx    = '0;
    res_status = ST_INVAL;
    if (!tail_r.en) begin
      // disabled: lookups miss with no slot, invalidates change nothing
      if (tail_r.action == ACT_LOOKUP) res_status = ST_NOSLOT;
    end else begin
      case (tail_r.action)
        ACT_LOOKUP: begin
          if (tail_r.found) begin
            is_hit     = 1'b1;
            res_status = ST_HIT;
            res_idx    = tail_r.hit_idx;
          end else if (tail_r.have) begin
            is_alloc   = 1'b1;
            res_status = ST_ALLOC;
            res_idx    = tail_r.pick;
          end else begin
            res_status = ST_NOSLOT;
          end
        end
        ACT_INV_ALL: is_clear = 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign res_idx_ext = {3'b000, res_idx};
  assign hit_nxt     = is_clear ? '0 : (is_hit ? hit_ctr_r + 1'b1 : hit_ctr_r);

  // commit broadcast, only while the scan word leaves the tail
  always_comb begin
    ctl.use_ctr   = use_ctr_r;
    ctl.alloc_we  = release_w && is_alloc;
    ctl.alloc_idx = tail_r.pick;
    ctl.alloc_tag = tail_r.lo;
    ctl.clear_all = release_w && is_clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      tail_r      <= '0;
      use_ctr_r   <= '0;
      hit_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) busy_r <= 1'b1;
      // tail holds the scan word until the output register is free
      if (chain[ENTRIES].vld) begin
        tail_r <= chain[ENTRIES];
      end else if (release_w) begin
        tail_r.vld <= 1'b0;
      end
      if (release_w) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        hit_ctr_r   <= hit_nxt;
        if (is_clear) begin
          use_ctr_r <= '0;
        end else if (is_hit || is_alloc) begin
          use_ctr_r <= use_ctr_r + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (release_w) begin
      out_status_r <= res_status;
      out_slot_r   <= res_idx_ext[2:0];
      out_hits_r   <= hit_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.slot      = out_slot_r;
  assign out_ch.hit_total = out_hits_r;

endmodule

/* verif/sector_cache_tag_lru_checker.sv */
// checker: predicts and compares the result words of the sector cache tag store
`timescale 1ns / 1ps
module sector_cache_tag_lru_checker
  import stc_pkg::*;
#(
  parameter logic [2:0] ENABLE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  stc_in_if           in_mon,
  stc_out_if          out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [15:0] hits;
  } result_t;

  // predicted copy of the tag store
  logic                ent_valid [ENTRIES];
  logic [TAG_BITS-1:0] ent_tag   [ENTRIES];
  logic [STAMP_W-1:0]  ent_stamp [ENTRIES];
  logic [STAMP_W-1:0]  use_ctr;
  logic [STAMP_W-1:0]  hit_ctr;
  logic                cache_on;

  result_t expected_q[$];

  function automatic void clear_tags();
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_tag[i]   = '0;
      ent_stamp[i] = '0;
    end
    use_ctr = '0;
    hit_ctr = '0;
  endfunction

  function automatic result_t lookup_or_invalidate(action_t act, logic [TAG_BITS-1:0] lo,
                                                   logic [TAG_BITS-1:0] hi);
    result_t          r;
    logic [STAMP_W:0] best;
    logic [STAMP_W:0] age;
    logic             have;
    logic             done;
    int               pick;
    r.status = ST_INVAL;
    r.slot   = '0;
    best     = '0;
    have     = 1'b0;
    done     = 1'b0;
    pick     = 0;
    if (!cache_on) begin
      if (act == ACT_LOOKUP) r.status = ST_NOSLOT;
    end else begin
      case (act)
        ACT_LOOKUP: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!done) begin
              if (!ent_valid[i]) begin
                // an empty entry outranks any age, the last one scanned wins
                pick = i;
                have = 1'b1;
                best = {1'b1, {STAMP_W{1'b0}}};
              end else if (ent_tag[i] == lo) begin
                ent_stamp[i] = use_ctr;
                use_ctr      = use_ctr + 1'b1;
                hit_ctr      = hit_ctr + 1'b1;
                r.status     = ST_HIT;
                r.slot       = i[2:0];
                done         = 1'b1;
              end else begin
                age = {1'b0, use_ctr - ent_stamp[i]};
                if (age > best) begin
                  pick = i;
                  have = 1'b1;
                  best = age;
                end
              end
            end
          end
          if (!done) begin
            if (!have) begin
              r.status = ST_NOSLOT;
            end else begin
              ent_valid[pick] = 1'b1;
              ent_tag[pick]   = lo;
              ent_stamp[pick] = use_ctr;
              use_ctr         = use_ctr + 1'b1;
              r.status        = ST_ALLOC;
              r.slot          = pick[2:0];
            end
          end
        end
        ACT_INV_ONE: begin
          // first stored tag match, valid or not
          for (int i = 0; i < ENTRIES; i++) begin
            if (!done && ent_tag[i] == lo) begin
              ent_valid[i] = 1'b0;
              done         = 1'b1;
            end
          end
        end
        ACT_INV_RANGE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (ent_tag[i] >= lo && ent_tag[i] <= hi) ent_valid[i] = 1'b0;
          end
        end
        default: clear_tags();
      endcase
    end
    r.hits = hit_ctr;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_tags();
      cache_on = 1'b1;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, status %0d slot %0d hits %0d", $time,
                   out_mon.status, out_mon.slot, out_mon.hit_total);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("slot", want.slot, out_mon.slot);
          check_field("hit_total", want.hits, out_mon.hit_total);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(lookup_or_invalidate(action_t'(in_mon.action), in_mon.sector,
                                                  in_mon.sector_last));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ENABLE_ADDR) begin
        cache_on = cfg_pwdata[0];
      end
    end
    pending = expected_q.size();
  end

endmodule

/* verif/sector_cache_tag_lru_tb.sv */
// testbench top: stimulus, handshake pacing and verdict for the sector cache tag store
`timescale 1ns / 1ps
module sector_cache_tag_lru_tb
  import stc_pkg::*;
();

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         POOL_SIZE      = 12;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;

  // small tag working set so that lookups hit, evict and get invalidated
  logic [31:0] tag_pool [POOL_SIZE];

  stc_in_if  in_if ();
  stc_out_if out_if ();

  sector_cache_tag_lru dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sector_cache_tag_lru_checker #(
    .ENABLE_ADDR (REG_ENABLE)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #1 clk = ~clk;

  // result side backpressure, one fresh draw per cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sector_cache_tag_lru test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request word; valid stays up across back to back words
  task automatic send_word(action_t act, logic [31:0] lo, logic [31:0] hi);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.sector      <= lo;
    in_if.sector_last <= hi;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // stop sending and let every outstanding result word come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // apb write of the enable register, only with the block idle
  task automatic set_enable(logic on);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ENABLE;
    cfg_pwdata  <= {31'b0, on};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // extremes plus a mix of scattered and clustered tags
  function automatic void refresh_pool();
    logic [31:0] base;
    base        = $urandom();
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      tag_pool[i] = (i % 2 == 1) ? $urandom() : base + i;
    end
  endfunction

  function automatic logic [31:0] pick_tag();
    if ($urandom_range(99, 0) < 88) return tag_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return $urandom();
  endfunction

  task automatic send_random();
    int          roll;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    logic        reversed;
    roll     = $urandom_range(99, 0);
    a        = pick_tag();
    b        = pick_tag();
    reversed = ($urandom_range(9, 0) == 0);
    if (roll < 66) begin
      send_word(ACT_LOOKUP, a, b);
    end else if (roll < 80) begin
      send_word(ACT_INV_ONE, a, b);
    end else if (roll < 98) begin
      // mostly ordered bounds, now and then an empty range
      if ((a > b) != reversed) begin
        t = a;
        a = b;
        b = t;
      end
      send_word(ACT_INV_RANGE, a, b);
    end else begin
      send_word(ACT_INV_ALL, a, b);
    end
  endtask

  // random words under one pacing mode, with a full drain halfway through
  task automatic run_phase(int tx_pct, int rx_pct, int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    refresh_pool();
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send_random();
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_LOOKUP;
    in_if.sector      <= '0;
    in_if.sector_last <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= REG_ENABLE;
    cfg_pwdata        <= '0;
    tx_idle_pct        = 20;
    rx_idle_pct        = 65;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_enable(1'b1);

    // directed: empty cache, fill, eviction, every invalidate flavor
    send_word(ACT_INV_ONE, '0, '0);             // zero tag of a never used entry
    send_word(ACT_LOOKUP, '0, '1);              // empty cache takes the last entry
    send_word(ACT_LOOKUP, '1, '0);
    send_word(ACT_LOOKUP, '0, '0);              // hit
    for (int t = 1; t <= 6; t++) send_word(ACT_LOOKUP, t, '1);
    send_word(ACT_LOOKUP, 32'h8000_0000, '0);   // full, oldest entry evicted
    send_word(ACT_INV_ONE, 32'h8000_0000, '0);
    send_word(ACT_INV_ONE, 32'h1234_5678, '0);  // no tag matches
    send_word(ACT_INV_RANGE, 32'd2, 32'd4);
    send_word(ACT_INV_RANGE, 32'd5, 32'd3);     // empty range
    send_word(ACT_LOOKUP, 32'd5, '0);
    send_word(ACT_LOOKUP, 32'd3, '0);           // refill while a stale copy of tag 3 sits
    send_word(ACT_INV_ONE, 32'd3, '0);          // first match is the stale invalid copy
    send_word(ACT_LOOKUP, 32'd3, '0);           // so the live copy still hits
    send_word(ACT_INV_RANGE, 32'd6, 32'd6);     // single point range
    send_word(ACT_INV_RANGE, '0, '1);           // whole tag space
    send_word(ACT_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(ACT_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(ACT_INV_ALL, '1, '1);
    send_word(ACT_LOOKUP, '1, '0);              // counters restart after invalidate-all

    // disabled: lookups miss without slot, invalidates leave the tags alone
    set_enable(1'b0);
    refresh_pool();
    repeat (20) send_random();
    set_enable(1'b1);

    run_phase(20, 65, 380);

    set_enable(1'b0);
    repeat (20) send_random();
    set_enable(1'b1);

    run_phase(65, 20, 380);
    run_phase(0, 0, 300);

    drain();
    repeat (ENTRIES + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sector_cache_tag_lru test passed");
    end else begin
      $display("sector_cache_tag_lru test failed");
    end
    $finish;
  end

endmodule
